@@ rtl/md5_pkg.sv @@
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_SLOT = 6'd56;

  function automatic logic [31:0] round_add(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;  6'd2: k = 32'h242070DB;
      6'd3: k = 32'hC1BDCEEE;  6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;  6'd8: k = 32'h698098D8;
      6'd9: k = 32'h8B44F7AF;  6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/md5_digest_engine.sv @@
// MD5 digest engine.
// Slave channel: one word per item; tdata[7:0] is the message byte, tuser[0]
// says the byte is present, tlast ends the message after that byte.
// Master channel: four digest words per message, tdata = digest_word,
// tuser = word_index, tlast on the fourth word.
// A word that carries no end and does not complete a 64-byte block is taken
// every cycle. A byte that completes a block holds the input while the 64
// rounds and the fold run; the next word is taken once the block is idle again.
// At end of message the block writes the padding into the buffer one byte a
// cycle, from the marker position to the end of the block, then runs the
// rounds and the fold. A marker past byte 55, or a final byte that fills
// the block, adds one more block of padding, rounds and fold.
// The block accepts no item until the fourth digest word has been taken, and
// a stalled receiver holds the current word. Round speed is set by the single
// adder/rotate chain that computes one MD5 step per cycle.
// Reset (rst, synchronous) loads the standard initial chaining words,
// clears the length and returns to idle; buffer contents are not cleared.
module md5_digest_engine
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast    // last_word
);

  state_t state, state_next;

  logic [31:0] buf_mem [16];   // block buffer, sixteen little-endian words
  logic [31:0] ha, hb, hc, hd; // chaining words
  logic [31:0] ra, rb, rc, rd; // working words
  logic [63:0] byte_total;
  logic [5:0]  rnd;            // round count
  logic [5:0]  pad_ptr;        // padding write pointer
  logic        pad_len;        // block being padded carries the length field
  logic        marked;         // 0x80 already placed
  logic        fin;            // current compression is part of finishing
  logic [1:0]  widx;

  // Accepted item
  logic acc;
  assign s_tready = (state == ST_IDLE);
  assign acc = s_tvalid && s_tready;

  // Round unit
  logic [31:0] f, sum, rot, mword;
  logic [3:0]  g;
  logic [4:0]  sh;

  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = (rb & rc) | (~rb & rd); g = rnd[3:0]; end
      2'd1: begin f = (rd & rb) | (~rd & rc); g = 4'(5 * rnd[3:0] + 1); end
      2'd2: begin f = rb ^ rc ^ rd;           g = 4'(3 * rnd[3:0] + 5); end
      default: begin f = rc ^ (rb | ~rd);     g = 4'(7 * rnd[3:0]); end
    endcase
  end

  assign mword = buf_mem[g];
  assign sh    = round_rot(rnd);
  assign sum   = ra + f + round_add(rnd) + mword;
  assign rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  logic [5:0] fill;
  logic [5:0] pad_start;
  assign fill = byte_total[5:0];
  // first pad position after the final byte
  assign pad_start = s_tuser ? fill + 6'd1 : fill;

  // Padding byte for pad_ptr: marker first, then zeros, length at the tail
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  assign bits = {byte_total[60:0], 3'b000};
  always_comb begin
    if (!marked)
      pad_byte = PAD_MARK;
    else if (pad_len && pad_ptr >= LEN_SLOT)
      pad_byte = bits[{pad_ptr[2:0], 3'b000} +: 8];
    else
      pad_byte = 8'h00;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) begin
        if (s_tuser && fill == 6'd63) state_next = ST_ROUND;
        else if (s_tlast)             state_next = ST_PAD;
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!fin)                   state_next = ST_IDLE;
        else if (marked && pad_len) state_next = ST_EMIT;
        else                        state_next = ST_PAD;
      end
      ST_PAD: if (pad_ptr == 6'd63) state_next = ST_ROUND;
      ST_EMIT: if (m_tready && widx == 2'd3) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Buffer writes
  always_ff @(posedge clk) begin
    if (acc && s_tuser)
      buf_mem[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= s_tdata;
    else if (state == ST_PAD)
      buf_mem[pad_ptr[5:2]][{pad_ptr[1:0], 3'b000} +: 8] <= pad_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ha <= IV_A; hb <= IV_B; hc <= IV_C; hd <= IV_D;
      byte_total <= '0;
      rnd <= '0; pad_ptr <= '0; pad_len <= 1'b0; fin <= 1'b0; widx <= '0;
      marked <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (acc) begin
          fin <= s_tlast;
          if (s_tuser) byte_total <= byte_total + 64'd1;
          ra <= ha; rb <= hb; rc <= hc; rd <= hd;
          rnd <= '0;
          pad_ptr <= pad_start;
          // length fits behind the marker in this block
          pad_len <= (pad_start < LEN_SLOT);
          marked <= 1'b0;
        end
        ST_ROUND: begin
          ra <= rd; rd <= rc; rc <= rb; rb <= rb + rot;
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          ha <= ha + ra; hb <= hb + rb; hc <= hc + rc; hd <= hd + rd;
          ra <= ha + ra; rb <= hb + rb; rc <= hc + rc; rd <= hd + rd;
          widx <= '0;
          // marker filled the block: the next block carries the length
          if (fin && marked && !pad_len) pad_len <= 1'b1;
        end
        ST_PAD: begin
          if (pad_ptr == 6'd63) begin
            rnd <= '0;
            ra <= ha; rb <= hb; rc <= hc; rd <= hd;
          end
          marked <= 1'b1;
          pad_ptr <= pad_ptr + 6'd1;
        end
        ST_EMIT: if (m_tready) begin
          widx <= widx + 2'd1;
          if (widx == 2'd3) begin
            ha <= IV_A; hb <= IV_B; hc <= IV_C; hd <= IV_D;
            byte_total <= '0;
            fin <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  logic [31:0] out_word;
  always_comb begin
    case (widx)
      2'd0: out_word = ha;
      2'd1: out_word = hb;
      2'd2: out_word = hc;
      default: out_word = hd;
    endcase
  end

  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = out_word;
  assign m_tuser  = widx;
  assign m_tlast  = (widx == 2'd3);

endmodule
